// ===== rtl/mmi_pkg.sv =====
// ----------------------------------------------------------------------------
// mmi_pkg
// Shared widths, codes and the sequencer state type of the modular
// matrix inverse block.
// ----------------------------------------------------------------------------
package mmi_pkg;

  localparam int MOD_W     = 16;  // modulus, element and result width
  localparam int DIM_W     = 4;   // dimension register width
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int BIT_W     = 4;   // bit counter of the serial multiplier

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOINV  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PASS_INIT,
    ST_SUB_CHK,
    ST_TERM_RD,
    ST_TERM_LD,
    ST_MUL,
    ST_TERM_ACC,
    ST_SUB_WR,
    ST_SUB_ADV,
    ST_INV_INIT,
    ST_INV_RUN,
    ST_COF_RD,
    ST_COF_LD,
    ST_COF_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_OUT_RANGE,
    ST_OUT_NOINV
  } state_t;

endpackage

// ===== rtl/mmi_ram.sv =====
// ----------------------------------------------------------------------------
// mmi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/modular_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_inverse
// Inverse of a square matrix over Z_m by the adjugate, with determinant and
// status, computed by one shared serial modular multiplier.
// ----------------------------------------------------------------------------
// Elements stream in row-major, one item per cycle, until dimension squared
// have arrived; then in_stall stays high while the block computes and emits.
// Compute for dimension d and a MOD_W-bit modulus: d+1 passes over the
// 2^d column subsets, each subset minor built term by term in the serial
// shift-add modular multiplier; then a search for the determinant's
// inverse by repeated modular addition (one modular add per cycle), d*d
// cofactor scalings in the same multiplier, and emission of the result
// items through a read state and a load state, held while out_stall keeps
// an item pending. An out-of-range element or a non-invertible determinant
// yields a single status item instead. The last item of a matrix has
// out_last_result set. The modulus and dimension registers may be written
// while no matrix is in the compute or emit phase.
// ----------------------------------------------------------------------------
module modular_matrix_inverse #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // element input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mmi_pkg::MOD_W-1:0]           in_element,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmi_pkg::MOD_W-1:0]           out_inverse_element,
  output logic [mmi_pkg::MOD_W-1:0]           out_determinant,
  output logic [mmi_pkg::STAT_W-1:0]          out_status,
  output logic                                out_last_result,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmi_pkg::MOD_W-1:0]           cfg_data
);

  localparam int W      = mmi_pkg::MOD_W;
  localparam int DW     = mmi_pkg::DIM_W;
  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int CW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int SW     = MAX_DIM;
  localparam int FDEPTH = 1 << MAX_DIM;

  mmi_pkg::state_t state_r, state_nxt;

  // configuration
  logic [W-1:0]      mod_r, mod_nxt;
  logic [DW-1:0]     dim_r, dim_nxt;
  // load
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rerr_r, rerr_nxt;
  // sequencer
  logic [DW-1:0]     p_r, p_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [DW-1:0]     c_r, c_nxt;
  logic [DW-1:0]     i_r, i_nxt;
  logic [W-1:0]      acc_r, acc_nxt;
  logic              cof_r, cof_nxt;
  // serial multiplier
  logic [W-1:0]      mx_r, mx_nxt;
  logic [W-1:0]      my_r, my_nxt;
  logic [W-1:0]      mp_r, mp_nxt;
  logic [mmi_pkg::BIT_W-1:0] bit_r, bit_nxt;
  // determinant and its inverse
  logic [W-1:0]      det_r, det_nxt;
  logic [W-1:0]      dinv_r, dinv_nxt;
  logic [W-1:0]      sx_r, sx_nxt;
  logic [W-1:0]      sp_r, sp_nxt;
  // emission
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              ov_r, ov_nxt;
  logic [W-1:0]      oinv_r, oinv_nxt;
  logic [W-1:0]      odet_r, odet_nxt;
  logic [mmi_pkg::STAT_W-1:0] ost_r, ost_nxt;
  logic              olast_r, olast_nxt;

  // RAM ports
  logic              st_we;
  logic [CW-1:0]     st_waddr, st_raddr;
  logic [W-1:0]      st_rdata;
  logic              f_we;
  logic [SW-1:0]     f_waddr, f_raddr;
  logic [W-1:0]      f_wdata, f_rdata;
  logic              ob_we;
  logic [CW-1:0]     ob_waddr, ob_raddr;
  logic [W-1:0]      ob_rdata;

  // ---------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------
  logic [DW-1:0]     eff_d;
  logic [7:0]        total;
  logic [SW-1:0]     full;
  logic              in_acc, out_free, range_bad, load_done;
  logic              last_s, last_c, last_i, last_p, det_pass;
  logic [DW-1:0]     dlim, kpc, row;
  logic              too_big, member, neg_term;
  logic [SW-1:0]     cbit, ibit, hi_mask;
  logic [7:0]        st_addr8, ob_addr8;
  logic [W-1:0]      base;

  always_comb begin
    if (dim_r == '0) begin
      eff_d = DW'(1);
    end else if ({1'b0, dim_r} > (DW+1)'(MAX_DIM)) begin
      eff_d = DW'(MAX_DIM);
    end else begin
      eff_d = dim_r;
    end
  end

  assign total     = {4'b0, eff_d} * {4'b0, eff_d};
  assign full      = SW'(((SW+1)'(1) << eff_d) - (SW+1)'(1));
  assign in_stall  = (state_r != mmi_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;
  assign range_bad = ({1'b0, in_element} >= {1'b0, mod_r});
  assign load_done = (10'(cnt_r) + 10'd1) >= 10'(total);
  assign base      = (mod_r == W'(1)) ? '0 : W'(1);

  assign det_pass = (p_r == eff_d);
  assign last_s   = (s_r == full);
  assign last_c   = (c_r == eff_d - DW'(1));
  assign last_i   = (i_r == eff_d - DW'(1));
  assign last_p   = (p_r == eff_d - DW'(1));

  // rows in use: all rows in the determinant pass, all but row p otherwise
  assign dlim    = det_pass ? eff_d : eff_d - DW'(1);
  assign kpc     = DW'($countones(s_r));
  assign too_big = (kpc > dlim);
  assign row     = ((kpc - DW'(1)) < p_r) ? kpc - DW'(1) : kpc;

  // column c of the subset and the parity of the columns above it
  assign cbit     = SW'(1) << c_r;
  assign ibit     = SW'(1) << i_r;
  assign member   = |(s_r & cbit);
  assign hi_mask  = s_r & ~((cbit << 1) - SW'(1));
  assign neg_term = ^hi_mask;

  assign st_addr8 = {4'b0, row} * {4'b0, eff_d} + {4'b0, c_r};
  assign ob_addr8 = {4'b0, i_r} * {4'b0, eff_d} + {4'b0, p_r};

  // ---------------------------------------------------------------------------
  // Shared modular arithmetic
  // ---------------------------------------------------------------------------
  logic [W:0] m17, dbl, dblr, addv, addr_sum, sum17, dif17, srch17;
  logic [W-1:0] mul_step, acc_upd, cof_val;

  assign m17 = {1'b0, mod_r};

  // one bit of the serial product, MSB first: mp = 2*mp + bit*y mod m
  always_comb begin
    dbl      = {mp_r, 1'b0};
    dblr     = (dbl >= m17) ? dbl - m17 : dbl;
    addv     = mx_r[W-1] ? {1'b0, my_r} : '0;
    addr_sum = dblr + addv;
    mul_step = (addr_sum >= m17) ? W'(addr_sum - m17) : W'(addr_sum);
  end

  // signed accumulation of a finished product
  always_comb begin
    sum17 = {1'b0, acc_r} + {1'b0, mp_r};
    dif17 = (acc_r >= mp_r) ? {1'b0, acc_r} - {1'b0, mp_r}
                            : {1'b0, acc_r} + m17 - {1'b0, mp_r};
    if (neg_term) begin
      acc_upd = W'(dif17);
    end else begin
      acc_upd = (sum17 >= m17) ? W'(sum17 - m17) : W'(sum17);
    end
  end

  assign srch17  = {1'b0, sp_r} + {1'b0, det_r};
  assign cof_val = ((i_r[0] ^ p_r[0]) && (f_rdata != '0)) ? mod_r - f_rdata : f_rdata;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmi_pkg::ST_IDLE: begin
        if (in_acc && load_done) begin
          state_nxt = (rerr_r || range_bad) ? mmi_pkg::ST_OUT_RANGE
                                            : mmi_pkg::ST_PASS_INIT;
        end
      end
      mmi_pkg::ST_PASS_INIT: state_nxt = mmi_pkg::ST_SUB_CHK;
      mmi_pkg::ST_SUB_CHK:   state_nxt = too_big ? mmi_pkg::ST_SUB_ADV : mmi_pkg::ST_TERM_RD;
      mmi_pkg::ST_TERM_RD: begin
        if (member) begin
          state_nxt = mmi_pkg::ST_TERM_LD;
        end else if (last_c) begin
          state_nxt = mmi_pkg::ST_SUB_WR;
        end
      end
      mmi_pkg::ST_TERM_LD:   state_nxt = mmi_pkg::ST_MUL;
      mmi_pkg::ST_MUL: begin
        if (bit_r == mmi_pkg::BIT_W'(W - 1)) begin
          state_nxt = cof_r ? mmi_pkg::ST_COF_WR : mmi_pkg::ST_TERM_ACC;
        end
      end
      mmi_pkg::ST_TERM_ACC:  state_nxt = last_c ? mmi_pkg::ST_SUB_WR : mmi_pkg::ST_TERM_RD;
      mmi_pkg::ST_SUB_WR:    state_nxt = mmi_pkg::ST_SUB_ADV;
      mmi_pkg::ST_SUB_ADV: begin
        if (!last_s) begin
          state_nxt = mmi_pkg::ST_SUB_CHK;
        end else if (det_pass) begin
          state_nxt = mmi_pkg::ST_INV_INIT;
        end else begin
          state_nxt = mmi_pkg::ST_COF_RD;
        end
      end
      mmi_pkg::ST_INV_INIT: begin
        state_nxt = (det_r == '0) ? mmi_pkg::ST_OUT_NOINV : mmi_pkg::ST_INV_RUN;
      end
      mmi_pkg::ST_INV_RUN: begin
        if (sp_r == W'(1)) begin
          state_nxt = mmi_pkg::ST_PASS_INIT;
        end else if (sx_r == mod_r - W'(1)) begin
          state_nxt = mmi_pkg::ST_OUT_NOINV;
        end
      end
      mmi_pkg::ST_COF_RD:    state_nxt = mmi_pkg::ST_COF_LD;
      mmi_pkg::ST_COF_LD:    state_nxt = mmi_pkg::ST_MUL;
      mmi_pkg::ST_COF_WR: begin
        if (!last_i) begin
          state_nxt = mmi_pkg::ST_COF_RD;
        end else if (last_p) begin
          state_nxt = mmi_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = mmi_pkg::ST_PASS_INIT;
        end
      end
      mmi_pkg::ST_EMIT_RD:   state_nxt = mmi_pkg::ST_EMIT_LD;
      mmi_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          state_nxt = ((10'(k_r) + 10'd1) == 10'(total)) ? mmi_pkg::ST_IDLE
                                                         : mmi_pkg::ST_EMIT_RD;
        end
      end
      mmi_pkg::ST_OUT_RANGE: if (out_free) state_nxt = mmi_pkg::ST_IDLE;
      mmi_pkg::ST_OUT_NOINV: if (out_free) state_nxt = mmi_pkg::ST_IDLE;
      default:               state_nxt = mmi_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    mod_nxt   = mod_r;
    dim_nxt   = dim_r;
    cnt_nxt   = cnt_r;
    rerr_nxt  = rerr_r;
    p_nxt     = p_r;
    s_nxt     = s_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    acc_nxt   = acc_r;
    cof_nxt   = cof_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    mp_nxt    = mp_r;
    bit_nxt   = bit_r;
    det_nxt   = det_r;
    dinv_nxt  = dinv_r;
    sx_nxt    = sx_r;
    sp_nxt    = sp_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && out_stall;   // drop the item once taken
    oinv_nxt  = oinv_r;
    odet_nxt  = odet_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;

    st_we    = 1'b0;
    st_waddr = CW'(cnt_r);
    st_raddr = CW'(st_addr8);
    f_we     = 1'b0;
    f_waddr  = s_r;
    f_wdata  = acc_r;
    f_raddr  = s_r & ~cbit;
    ob_we    = 1'b0;
    ob_waddr = CW'(ob_addr8);
    ob_raddr = CW'(k_r);

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mmi_pkg::CFG_MODULUS:   mod_nxt = cfg_data;
        mmi_pkg::CFG_DIMENSION: dim_nxt = cfg_data[DW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      mmi_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_we = 1'b1;
          if (load_done) begin
            cnt_nxt  = '0;
            rerr_nxt = 1'b0;
            p_nxt    = eff_d;   // determinant pass first
          end else begin
            cnt_nxt  = cnt_r + CNT_W'(1);
            rerr_nxt = rerr_r || range_bad;
          end
        end
      end
      mmi_pkg::ST_PASS_INIT: begin
        // empty minor is one
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = base;
        s_nxt   = SW'(1);
      end
      mmi_pkg::ST_SUB_CHK: begin
        acc_nxt = '0;
        c_nxt   = '0;
      end
      mmi_pkg::ST_TERM_RD: begin
        if (!member && !last_c) begin
          c_nxt = c_r + DW'(1);
        end
      end
      mmi_pkg::ST_TERM_LD: begin
        mx_nxt  = st_rdata;
        my_nxt  = f_rdata;
        mp_nxt  = '0;
        bit_nxt = '0;
        cof_nxt = 1'b0;
      end
      mmi_pkg::ST_MUL: begin
        mp_nxt  = mul_step;
        mx_nxt  = {mx_r[W-2:0], 1'b0};
        bit_nxt = bit_r + mmi_pkg::BIT_W'(1);
      end
      mmi_pkg::ST_TERM_ACC: begin
        acc_nxt = acc_upd;
        if (!last_c) begin
          c_nxt = c_r + DW'(1);
        end
      end
      mmi_pkg::ST_SUB_WR: begin
        f_we = 1'b1;
        if (det_pass && last_s) begin
          det_nxt = acc_r;
        end
      end
      mmi_pkg::ST_SUB_ADV: begin
        if (!last_s) begin
          s_nxt = s_r + SW'(1);
        end
        i_nxt = '0;
      end
      mmi_pkg::ST_INV_INIT: begin
        sp_nxt = det_r;
        sx_nxt = W'(1);
      end
      mmi_pkg::ST_INV_RUN: begin
        if (sp_r == W'(1)) begin
          dinv_nxt = sx_r;
          p_nxt    = '0;
        end else begin
          sx_nxt = sx_r + W'(1);
          sp_nxt = (srch17 >= m17) ? W'(srch17 - m17) : W'(srch17);
        end
      end
      mmi_pkg::ST_COF_RD: begin
        f_raddr = full & ~ibit;
      end
      mmi_pkg::ST_COF_LD: begin
        f_raddr = full & ~ibit;
        mx_nxt  = cof_val;
        my_nxt  = dinv_r;
        mp_nxt  = '0;
        bit_nxt = '0;
        cof_nxt = 1'b1;
      end
      mmi_pkg::ST_COF_WR: begin
        // inverse[i][p] = cofactor of (p, i) times the determinant's inverse
        ob_we = 1'b1;
        if (!last_i) begin
          i_nxt = i_r + DW'(1);
        end else if (last_p) begin
          k_nxt = '0;
        end else begin
          p_nxt = p_r + DW'(1);
        end
      end
      mmi_pkg::ST_EMIT_RD: ;
      mmi_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oinv_nxt  = ob_rdata;
          odet_nxt  = det_r;
          ost_nxt   = mmi_pkg::STAT_OK;
          olast_nxt = ((10'(k_r) + 10'd1) == 10'(total));
          k_nxt     = k_r + CNT_W'(1);
        end
      end
      mmi_pkg::ST_OUT_RANGE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oinv_nxt  = '0;
          odet_nxt  = '0;
          ost_nxt   = mmi_pkg::STAT_RANGE;
          olast_nxt = 1'b1;
        end
      end
      mmi_pkg::ST_OUT_NOINV: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oinv_nxt  = '0;
          odet_nxt  = det_r;
          ost_nxt   = mmi_pkg::STAT_NOINV;
          olast_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmi_pkg::ST_IDLE;
      mod_r   <= W'(26);
      dim_r   <= DW'(2);
      cnt_r   <= '0;
      rerr_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mod_r   <= mod_nxt;
      dim_r   <= dim_nxt;
      cnt_r   <= cnt_nxt;
      rerr_r  <= rerr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    s_r     <= s_nxt;
    c_r     <= c_nxt;
    i_r     <= i_nxt;
    acc_r   <= acc_nxt;
    cof_r   <= cof_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    mp_r    <= mp_nxt;
    bit_r   <= bit_nxt;
    det_r   <= det_nxt;
    dinv_r  <= dinv_nxt;
    sx_r    <= sx_nxt;
    sp_r    <= sp_nxt;
    k_r     <= k_nxt;
    oinv_r  <= oinv_nxt;
    odet_r  <= odet_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  // ---------------------------------------------------------------------------
  // Memories: raw elements, subset minors, finished inverse
  // ---------------------------------------------------------------------------
  mmi_ram #(.WIDTH(W), .DEPTH(CELLS), .AW(CW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_element),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mmi_ram #(.WIDTH(W), .DEPTH(FDEPTH), .AW(SW)) u_minor (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  mmi_ram #(.WIDTH(W), .DEPTH(CELLS), .AW(CW)) u_result (
    .clk   (clk),
    .we    (ob_we),
    .waddr (ob_waddr),
    .wdata (mp_r),
    .raddr (ob_raddr),
    .rdata (ob_rdata)
  );

  assign cfg_ready           = 1'b1;
  assign out_valid           = ov_r;
  assign out_inverse_element = oinv_r;
  assign out_determinant     = odet_r;
  assign out_status          = ost_r;
  assign out_last_result     = olast_r;

endmodule
